// ===== sv/tbar_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank package
// Commands, status codes, sequencer states and shared types of the timer bank.
// ----------------------------------------------------------------------------
`default_nettype none

package tbar_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_REG   = 2'd1;
  localparam logic [1:0] CMD_REM   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;

  localparam logic [30:0] RETIRE_RESET = 31'd655360;
  localparam logic [31:0] S32_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN      = 32'h8000_0000;
  localparam logic [31:0] U32_MAX      = 32'hffff_ffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TK_RD,
    ST_TK_ADD,
    ST_TK_CMP,
    ST_TK_WB,
    ST_Q_RD,
    ST_Q_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] cur;
    logic [31:0] rld;
    logic [31:0] tgt;
    logic        reloads;
    logic        down;
    logic        fired;
    logic [31:0] tpe;
  } slot_t;

  typedef struct packed {
    logic signed [33:0] add_a;
    logic signed [33:0] add_b;
    logic               sub;
    logic signed [32:0] cmp_a;
    logic signed [32:0] cmp_b;
  } alu_req_t;

  typedef struct packed {
    logic signed [33:0] sum;
    logic               lt;
    logic               eq;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/tbar_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/tbar_alu.sv =====
// ----------------------------------------------------------------------------
// Timer bank shared arithmetic unit
// One wide adder/subtractor and one signed magnitude comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module tbar_alu
  import tbar_pkg::*;
(
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  always_comb begin
    rsp_o.sum = req_i.sub ? (req_i.add_a - req_i.add_b) : (req_i.add_a + req_i.add_b);
    rsp_o.lt  = (req_i.cmp_a < req_i.cmp_b);
    rsp_o.eq  = (req_i.cmp_a == req_i.cmp_b);
  end

endmodule

`default_nettype wire

// ===== sv/timer_bank_with_auto_retire_unit.sv =====
// Tick walks every slot: a free slot is skipped in the read state, and a live slot
//   goes through read, add, compare and write-back. Register scans up to the first free slot.
// Throughput: one word at a time; a new word is taken once the previous one
//   is in the output register. Tick cost is set by the slot RAM read latency
//   and the single shared adder/comparator used three times per live slot.
// Reset: all slots free, retire time 10.0, output empty; slot RAM is not cleared.
// ----------------------------------------------------------------------------
// Timer bank with automatic retirement
// Sequencer walking a slot RAM through one shared adder and comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_bank_with_auto_retire_unit
  import tbar_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [30:0]   cfg_data_i,      // retire_after
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [103:0]  s_axis_tdata,    // delta, start_time, deadline, loop_mode, key
  input  wire logic [1:0]    s_axis_tuser,    // cmd
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [7:0]         m_axis_tdata     // slot, ended, status
);

  localparam int IW = $clog2(SLOTS);
  localparam int SW = $bits(slot_t);

  state_e state_q, state_d;

  logic [SLOTS-1:0] live_q;
  logic [IW-1:0]    idx_q;
  logic [30:0]      retire_q;

  logic [1:0]  cmd_q;
  logic [30:0] delta_q;
  logic [31:0] start_q;
  logic [31:0] dl_q;
  logic        loop_q;
  logic [3:0]  key_q;

  logic [31:0] v_q;
  logic        reach_q;
  logic [31:0] tpe_new_q;

  logic [3:0]  res_slot_q;
  logic        res_ended_q;
  logic [1:0]  res_status_q;

  logic        m_valid_q;
  logic [7:0]  m_data_q;

  logic          in_acc;
  logic [3:0]    in_key;
  logic          in_key_ok;
  logic          key_ok;
  logic [IW-1:0] key_idx;
  logic          idx_last;
  logic          out_free;
  logic          out_load;

  logic          ram_we;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  slot_t         ram_wdata;
  logic [SW-1:0] ram_rdata;
  slot_t         rd;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic     reach;
  logic     retire;
  logic [31:0] v_sat;
  logic [31:0] tpe_sat;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign in_key      = s_axis_tdata[99:96];
  assign in_key_ok   = (32'(in_key) < 32'(SLOTS));
  assign key_ok      = (32'(key_q) < 32'(SLOTS));
  assign key_idx     = IW'(key_q);
  assign idx_last    = (idx_q == IW'(SLOTS - 1));
  assign out_free    = !m_valid_q || m_axis_tready;
  assign out_load    = (state_q == ST_DONE) && out_free;
  assign rd          = slot_t'(ram_rdata);
  assign reach       = rd.down ? (alu_rsp.lt || alu_rsp.eq) : !alu_rsp.lt;
  assign retire      = !rd.reloads && reach_q && alu_rsp.lt;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    if (alu_rsp.sum[33:31] != {3{alu_rsp.sum[33]}}) begin
      v_sat = alu_rsp.sum[33] ? S32_MIN : S32_MAX;
    end else begin
      v_sat = alu_rsp.sum[31:0];
    end
    tpe_sat = (alu_rsp.sum[33:32] != 2'b00) ? U32_MAX : alu_rsp.sum[31:0];
  end

  tbar_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  tbar_ram #(
    .WIDTH (SW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            CMD_TICK: state_d = ST_TK_RD;
            CMD_REG:  state_d = ST_SCAN;
            CMD_REM:  state_d = ST_DONE;
            default:  state_d = ST_Q_RD;
          endcase
        end
      end
      ST_SCAN: begin
        if (!live_q[idx_q] || idx_last) state_d = ST_DONE;
      end
      ST_TK_RD: begin
        if (live_q[idx_q]) begin
          state_d = ST_TK_ADD;
        end else if (idx_last) begin
          state_d = ST_DONE;
        end
      end
      ST_TK_ADD: state_d = ST_TK_CMP;
      ST_TK_CMP: state_d = ST_TK_WB;
      ST_TK_WB:  state_d = idx_last ? ST_DONE : ST_TK_RD;
      ST_Q_RD:   state_d = (key_ok && live_q[key_idx]) ? ST_Q_CMP : ST_DONE;
      ST_Q_CMP:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    ram_we    = 1'b0;
    ram_wdata = rd;
    alu_req   = '0;
    case (state_q)
      ST_SCAN: begin
        alu_req.cmp_a       = {dl_q[31], dl_q};
        alu_req.cmp_b       = {start_q[31], start_q};
        ram_we              = !live_q[idx_q];
        ram_wdata.cur       = start_q;
        ram_wdata.rld       = start_q;
        ram_wdata.tgt       = dl_q;
        ram_wdata.reloads   = loop_q;
        ram_wdata.down      = alu_rsp.lt;
        ram_wdata.fired     = 1'b0;
        ram_wdata.tpe       = '0;
      end
      ST_TK_RD: begin
        ram_re = live_q[idx_q];
      end
      ST_TK_ADD: begin
        alu_req.add_a = {{2{rd.cur[31]}}, rd.cur};
        alu_req.add_b = {3'b000, delta_q};
        alu_req.sub   = rd.down;
      end
      ST_TK_CMP: begin
        alu_req.cmp_a = {v_q[31], v_q};
        alu_req.cmp_b = {rd.tgt[31], rd.tgt};
        alu_req.add_a = {2'b00, rd.tpe};
        alu_req.add_b = {3'b000, delta_q};
      end
      ST_TK_WB: begin
        alu_req.cmp_a   = {2'b00, retire_q};
        alu_req.cmp_b   = {1'b0, tpe_new_q};
        ram_we          = 1'b1;
        ram_wdata.cur   = (rd.reloads && reach_q) ? rd.rld : v_q;
        ram_wdata.fired = rd.reloads && reach_q;
        ram_wdata.tpe   = (!rd.reloads && reach_q) ? tpe_new_q : rd.tpe;
      end
      ST_Q_RD: begin
        ram_re    = 1'b1;
        ram_raddr = key_idx;
      end
      ST_Q_CMP: begin
        alu_req.cmp_a = {rd.cur[31], rd.cur};
        alu_req.cmp_b = {rd.tgt[31], rd.tgt};
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      live_q    <= '0;
      retire_q  <= RETIRE_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        retire_q <= cfg_data_i;
      end
      if (in_acc && s_axis_tuser == CMD_REM && in_key_ok) begin
        live_q[IW'(in_key)] <= 1'b0;
      end
      if (state_q == ST_SCAN && !live_q[idx_q]) begin
        live_q[idx_q] <= 1'b1;
      end
      if (state_q == ST_TK_WB && retire) begin
        live_q[idx_q] <= 1'b0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q        <= s_axis_tuser;
      delta_q      <= s_axis_tdata[30:0];
      start_q      <= s_axis_tdata[62:31];
      dl_q         <= s_axis_tdata[94:63];
      loop_q       <= s_axis_tdata[95];
      key_q        <= in_key;
      idx_q        <= '0;
      res_slot_q   <= in_key;
      res_ended_q  <= 1'b0;
      res_status_q <= STAT_OK;
    end
    case (state_q)
      ST_SCAN: begin
        if (!live_q[idx_q]) begin
          res_slot_q <= 4'(idx_q);
        end else if (idx_last) begin
          res_status_q <= STAT_FULL;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      ST_TK_RD: begin
        if (!live_q[idx_q] && !idx_last) idx_q <= idx_q + 1'b1;
      end
      ST_TK_ADD: v_q <= v_sat;
      ST_TK_CMP: begin
        reach_q   <= reach;
        tpe_new_q <= tpe_sat;
      end
      ST_TK_WB: begin
        if (!idx_last) idx_q <= idx_q + 1'b1;
      end
      ST_Q_RD: begin
        if (!(key_ok && live_q[key_idx])) begin
          res_ended_q  <= 1'b1;
          res_status_q <= STAT_ABSENT;
        end
      end
      ST_Q_CMP: res_ended_q <= rd.reloads ? rd.fired : reach;
      default: begin
        if (out_load) m_data_q <= {1'b0, res_status_q, res_ended_q, res_slot_q};
      end
    endcase
  end

`ifndef SYNTH
  a_live_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !in_acc) |=> $stable(live_q))
    else $error("live bits changed while idle");

  a_ram_we_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_TK_WB || state_q == ST_SCAN))
    else $error("slot RAM written outside allocate or write-back");

  a_full_all_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == STAT_FULL) |-> (&live_q))
    else $error("table full reported with a free slot");

  a_add_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TK_ADD) |-> ($past(state_q) == ST_TK_RD))
    else $error("tick add without a preceding slot read");

  a_full_only_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res_status_q == STAT_FULL) |-> (cmd_q == CMD_REG))
    else $error("table full status on a non-register word");
`endif

endmodule

`default_nettype wire
